>>> hdl/multi_level_order_flow_imbalance_assert.svh
// Assertion macros shared by the RTL of the order flow imbalance block.
`ifndef MULTI_LEVEL_ORDER_FLOW_IMBALANCE_ASSERT_SVH
`define MULTI_LEVEL_ORDER_FLOW_IMBALANCE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MLOFI_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MLOFI_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/mlofi_pkg.sv
package mlofi_pkg;

   // Field widths of the level words.
   localparam int PRICE_W = 32;
   localparam int QTY_W   = 32;
   localparam int INDEX_W = 4;
   localparam int LVL_W   = 34;
   localparam int DEEP_W  = 38;
   localparam int MID_W   = 33;
   localparam int COUNT_W = 5;

   // Absolute ceiling on levels that the index field can name.
   localparam int INDEX_LIMIT = 16;

   // Reset value of the level count register.
   localparam logic [COUNT_W-1:0] LEVEL_COUNT_RESET = 5'd5;

   // One stored book level, as kept in the level memory.
   typedef struct packed {
      logic [PRICE_W-1:0] bid_price;
      logic [QTY_W-1:0]   bid_quantity;
      logic [PRICE_W-1:0] ask_price;
      logic [QTY_W-1:0]   ask_quantity;
      logic               bid_present;
      logic               ask_present;
   } entry_type;

   // Stage A: incoming level plus its sequencing context.
   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic               last;
      logic               have_previous;
      entry_type          cur;
   } stage_a_type;

   // Stage B: per-side depth changes.
   typedef struct packed {
      logic [INDEX_W-1:0]      index;
      logic                    last;
      logic                    counted;
      logic                    two_sided;
      logic signed [LVL_W-1:0] bid_delta;
      logic signed [LVL_W-1:0] ask_delta;
      logic [MID_W-1:0]        mid;
   } stage_b_type;

   // Stage C: level imbalance.
   typedef struct packed {
      logic [INDEX_W-1:0]      index;
      logic                    last;
      logic                    counted;
      logic                    two_sided;
      logic signed [LVL_W-1:0] imbalance;
      logic [MID_W-1:0]        mid;
   } stage_c_type;

   // Stage D: the result word and the running snapshot holds.
   typedef struct packed {
      logic [INDEX_W-1:0]       index;
      logic signed [LVL_W-1:0]  imbalance;
      logic                     counted;
      logic signed [DEEP_W-1:0] deep;
      logic signed [LVL_W-1:0]  top;
      logic                     top_valid;
      logic [MID_W-1:0]         mid;
      logic                     mid_valid;
      logic                     last;
   } stage_d_type;

   // Bid depth change: a higher price counts the new queue, a lower one
   // removes the old queue, an equal one counts the queue difference.
   function automatic logic signed [LVL_W-1:0] bid_change(
      input logic [PRICE_W-1:0] cur_price,
      input logic [QTY_W-1:0]   cur_qty,
      input logic [PRICE_W-1:0] prev_price,
      input logic [QTY_W-1:0]   prev_qty
   );
      logic signed [LVL_W-1:0] cq;
      logic signed [LVL_W-1:0] pq;
      cq = signed'({{(LVL_W-QTY_W){1'b0}}, cur_qty});
      pq = signed'({{(LVL_W-QTY_W){1'b0}}, prev_qty});
      if (cur_price > prev_price) begin
         return cq;
      end else if (cur_price == prev_price) begin
         return cq - pq;
      end else begin
         return -pq;
      end
   endfunction

   // Ask depth change: the same rule with a lower price as the improvement.
   function automatic logic signed [LVL_W-1:0] ask_change(
      input logic [PRICE_W-1:0] cur_price,
      input logic [QTY_W-1:0]   cur_qty,
      input logic [PRICE_W-1:0] prev_price,
      input logic [QTY_W-1:0]   prev_qty
   );
      logic signed [LVL_W-1:0] cq;
      logic signed [LVL_W-1:0] pq;
      cq = signed'({{(LVL_W-QTY_W){1'b0}}, cur_qty});
      pq = signed'({{(LVL_W-QTY_W){1'b0}}, prev_qty});
      if (cur_price < prev_price) begin
         return cq;
      end else if (cur_price == prev_price) begin
         return cq - pq;
      end else begin
         return -pq;
      end
   endfunction

endpackage

>>> hdl/mlofi_ram.sv
module mlofi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Registered read; a read and a write of one entry in the same cycle
   // return the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

>>> hdl/multi_level_order_flow_imbalance.sv
// Multi-level order flow imbalance. A book snapshot arrives as a run of
// level words, level 0 first, one level per word; the run length is the
// level count register (0 acts as 1, values above the smaller of MAX_LEVELS
// and 16 saturate). Each accepted word gives one result word. The block takes
// one level word per clock; its result passes through the registered stages A,
// B, C and D, and the pipeline only stops when the result side holds off.
// The previous snapshot lives in one level memory that is read and rewritten
// in the cycle a level word is accepted, so a level that repeats in the next
// word (a one-level snapshot) already sees the new contents. Per-entry valid
// bits, cleared by reset, stand in for a zeroed memory, so no clearing pass is
// needed and words are accepted from the first cycle after reset.
`include "multi_level_order_flow_imbalance_assert.svh"

module multi_level_order_flow_imbalance
   import mlofi_pkg::*;
#(
   parameter int MAX_LEVELS = 16
) (
   input  logic          clock,
   input  logic          reset,
   // Level count register.
   input  logic          csr_wr_en,
   input  logic [4:0]    csr_wr_data,
   // Level word in. tdata: bid_price, bid_quantity, ask_price, ask_quantity.
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,
   // tuser: bid_present, ask_present.
   input  logic [1:0]    req_tuser,
   // Result word out. tdata: level_index, level_imbalance, deep_imbalance,
   // top_imbalance, mid_doubled, one zero pad bit.
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [143:0]  rsp_tdata,
   // tuser: level_counted, top_valid, mid_valid.
   output logic [2:0]    rsp_tuser,
   output logic          rsp_tlast
);

   localparam int ADDR_W      = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int LEVEL_LIMIT = (MAX_LEVELS < INDEX_LIMIT) ? MAX_LEVELS : INDEX_LIMIT;
   localparam int ENTRY_W     = $bits(entry_type);

   // Sequencing state.
   logic [COUNT_W-1:0]    level_count_ff, level_count_in;
   logic [INDEX_W-1:0]    position_ff, position_in;
   logic                  have_prev_ff, have_prev_in;
   logic [MAX_LEVELS-1:0] entry_valid_ff, entry_valid_in;

   // Pipeline stages.
   logic        a_valid_ff, a_valid_in;
   logic        b_valid_ff, b_valid_in;
   logic        c_valid_ff, c_valid_in;
   logic        d_valid_ff, d_valid_in;
   stage_a_type a_ff, a_in;
   logic        a_entry_valid_ff, a_entry_valid_in;
   stage_b_type b_ff, b_in;
   stage_c_type c_ff, c_in;
   stage_d_type d_ff, d_in;

   logic rdy_a, rdy_b, rdy_c, rdy_d;
   logic accept;

   logic [COUNT_W-1:0] levels;
   logic [INDEX_W-1:0] level_sel;
   logic               level_last;
   logic [ADDR_W-1:0]  addr;

   entry_type cur_entry;
   entry_type prev_entry;
   logic [ENTRY_W-1:0] ram_rd_data;

   // Effective run length and the level of the word now offered.
   always_comb begin
      if (level_count_ff == '0) begin
         levels = COUNT_W'(1);
      end else if (level_count_ff > COUNT_W'(LEVEL_LIMIT)) begin
         levels = COUNT_W'(LEVEL_LIMIT);
      end else begin
         levels = level_count_ff;
      end
      if ({1'b0, position_ff} >= levels) begin
         level_sel = INDEX_W'(levels - COUNT_W'(1));
      end else begin
         level_sel = position_ff;
      end
      level_last = (({1'b0, level_sel} + COUNT_W'(1)) >= levels);
      addr       = ADDR_W'(level_sel);
   end

   // Ready chain; a stage takes a new word when it is empty or moving on.
   assign rdy_d      = !d_valid_ff || rsp_tready;
   assign rdy_c      = !c_valid_ff || rdy_d;
   assign rdy_b      = !b_valid_ff || rdy_c;
   assign rdy_a      = !a_valid_ff || rdy_b;
   assign req_tready = rdy_a;
   assign accept     = req_tvalid && rdy_a;

   assign cur_entry.bid_price    = req_tdata[31:0];
   assign cur_entry.bid_quantity = req_tdata[63:32];
   assign cur_entry.ask_price    = req_tdata[95:64];
   assign cur_entry.ask_quantity = req_tdata[127:96];
   assign cur_entry.bid_present  = req_tuser[0];
   assign cur_entry.ask_present  = req_tuser[1];

   // Level memory: read the old entry and write the new one on accept.
   mlofi_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_LEVELS)
   ) u_level_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (addr),
      .wr_data (cur_entry),
      .rd_en   (accept),
      .rd_addr (addr),
      .rd_data (ram_rd_data)
   );

   assign prev_entry = entry_type'(ram_rd_data);

   // Configuration and snapshot sequencing.
   always_comb begin
      level_count_in = level_count_ff;
      position_in    = position_ff;
      have_prev_in   = have_prev_ff;
      entry_valid_in = entry_valid_ff;
      if (csr_wr_en) begin
         level_count_in = csr_wr_data;
      end
      if (accept) begin
         entry_valid_in[addr] = 1'b1;
         if (level_last) begin
            position_in  = '0;
            have_prev_in = 1'b1;
         end else begin
            position_in = level_sel + INDEX_W'(1);
         end
      end
   end

   // Stage A: register the word with its level and context.
   always_comb begin
      a_valid_in       = a_valid_ff;
      a_in             = a_ff;
      a_entry_valid_in = a_entry_valid_ff;
      if (rdy_a) begin
         a_valid_in = req_tvalid;
      end
      if (accept) begin
         a_in.index         = level_sel;
         a_in.last          = level_last;
         a_in.have_previous = have_prev_ff;
         a_in.cur           = cur_entry;
         a_entry_valid_in   = entry_valid_ff[addr];
      end
   end

   // Stage B: depth change of each side against the stored level.
   always_comb begin
      b_valid_in = b_valid_ff;
      b_in       = b_ff;
      if (rdy_b) begin
         b_valid_in = a_valid_ff;
         if (a_valid_ff) begin
            b_in.index     = a_ff.index;
            b_in.last      = a_ff.last;
            b_in.two_sided = a_ff.cur.bid_present && a_ff.cur.ask_present;
            b_in.counted   = a_ff.have_previous && a_ff.cur.bid_present
                             && a_ff.cur.ask_present && a_entry_valid_ff
                             && prev_entry.bid_present && prev_entry.ask_present;
            b_in.bid_delta = bid_change(a_ff.cur.bid_price, a_ff.cur.bid_quantity,
                                        prev_entry.bid_price, prev_entry.bid_quantity);
            b_in.ask_delta = ask_change(a_ff.cur.ask_price, a_ff.cur.ask_quantity,
                                        prev_entry.ask_price, prev_entry.ask_quantity);
            if (a_ff.cur.bid_present && a_ff.cur.ask_present) begin
               b_in.mid = {1'b0, a_ff.cur.bid_price} + {1'b0, a_ff.cur.ask_price};
            end else begin
               b_in.mid = '0;
            end
         end
      end
   end

   // Stage C: level imbalance, zero when the level does not count.
   always_comb begin
      c_valid_in = c_valid_ff;
      c_in       = c_ff;
      if (rdy_c) begin
         c_valid_in = b_valid_ff;
         if (b_valid_ff) begin
            c_in.index     = b_ff.index;
            c_in.last      = b_ff.last;
            c_in.counted   = b_ff.counted;
            c_in.two_sided = b_ff.two_sided;
            c_in.mid       = b_ff.mid;
            c_in.imbalance = b_ff.counted ? (b_ff.bid_delta - b_ff.ask_delta) : '0;
         end
      end
   end

   // Stage D: running deep sum and level-0 holds; this is the result word.
   always_comb begin
      d_valid_in = d_valid_ff;
      d_in       = d_ff;
      if (rdy_d) begin
         d_valid_in = c_valid_ff;
         if (c_valid_ff) begin
            d_in.index     = c_ff.index;
            d_in.imbalance = c_ff.imbalance;
            d_in.counted   = c_ff.counted;
            d_in.last      = c_ff.last;
            if (c_ff.index == '0) begin
               d_in.deep      = DEEP_W'(c_ff.imbalance);
               d_in.top       = c_ff.imbalance;
               d_in.top_valid = c_ff.counted;
               d_in.mid       = c_ff.mid;
               d_in.mid_valid = c_ff.two_sided;
            end else begin
               d_in.deep = d_ff.deep + DEEP_W'(c_ff.imbalance);
            end
         end
      end
   end

   // Control state with reset; payload registers run free.
   always_ff @(posedge clock) begin
      if (reset) begin
         level_count_ff <= LEVEL_COUNT_RESET;
         position_ff    <= '0;
         have_prev_ff   <= 1'b0;
         entry_valid_ff <= '0;
         a_valid_ff     <= 1'b0;
         b_valid_ff     <= 1'b0;
         c_valid_ff     <= 1'b0;
         d_valid_ff     <= 1'b0;
      end else begin
         level_count_ff <= level_count_in;
         position_ff    <= position_in;
         have_prev_ff   <= have_prev_in;
         entry_valid_ff <= entry_valid_in;
         a_valid_ff     <= a_valid_in;
         b_valid_ff     <= b_valid_in;
         c_valid_ff     <= c_valid_in;
         d_valid_ff     <= d_valid_in;
      end
      a_ff             <= a_in;
      a_entry_valid_ff <= a_entry_valid_in;
      b_ff             <= b_in;
      c_ff             <= c_in;
      d_ff             <= d_in;
   end

   // Result word.
   assign rsp_tvalid = d_valid_ff;
   assign rsp_tdata  = {1'b0, d_ff.mid, d_ff.top, d_ff.deep, d_ff.imbalance, d_ff.index};
   assign rsp_tuser  = {d_ff.mid_valid, d_ff.top_valid, d_ff.counted};
   assign rsp_tlast  = d_ff.last;

   // An uncounted level never carries an imbalance.
   `MLOFI_ASSERT_IMP(a_uncounted_zero, clock, reset, d_valid_ff && !d_ff.counted, d_ff.imbalance == '0, "uncounted level with nonzero imbalance")
   // A counted top level implies a two-sided top level.
   `MLOFI_ASSERT_IMP(a_top_needs_mid, clock, reset, d_valid_ff && d_ff.top_valid, d_ff.mid_valid, "top valid without a two-sided top level")
   // Mid is zero whenever the top level was one-sided.
   `MLOFI_ASSERT_IMP(a_mid_zero, clock, reset, d_valid_ff && !d_ff.mid_valid, d_ff.mid == '0, "mid nonzero for a one-sided top level")
   // A word inside a snapshot moves the position on by one level.
   `MLOFI_ASSERT_NXT(a_pos_step, clock, reset, accept && !level_last, position_ff == ($past(level_sel) + INDEX_W'(1)), "level position did not advance")
   // The last word of a snapshot rewinds and marks a previous snapshot.
   `MLOFI_ASSERT_NXT(a_pos_wrap, clock, reset, accept && level_last, (position_ff == '0) && have_prev_ff, "snapshot end did not rewind")

endmodule
